[sv/lab_pkg.sv]
// ----------------------------------------------------------------------------
// Line assembler package
// Shared types and constants for the line assembler with overlong discard.
// ----------------------------------------------------------------------------
package lab_pkg;

    // Line end characters.
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Reader buffer size: reset value and saturation limit.
    localparam logic [6:0] CAP_RESET = 7'd64;
    localparam logic [6:0] CAP_MAX   = 7'd64;

    // At most CAP_MAX-1 bytes leave per line, so a count fits in six bits.
    localparam int CNT_W = 6;

    // Depth of the command queue between front and back.
    localparam int CMD_Q_DEPTH = 2;
    localparam int CMD_Q_AW    = $clog2(CMD_Q_DEPTH);

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_TOO_LONG = 2'd2
    } kind_t;

    // One command from the front to the back.
    typedef struct packed {
        kind_t             kind;
        logic [CNT_W-1:0]  count;
    } cmd_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // Read-out sequencer states.
    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_EMIT
    } b_state_t;

endpackage

[sv/lab_in_if.sv]
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one received character per transfer.
// ----------------------------------------------------------------------------
interface lab_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[sv/lab_out_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one line byte, empty-line or error result.
// ----------------------------------------------------------------------------
interface lab_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output kind, output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

[sv/line_assembler_overlong_discard.sv]
// ----------------------------------------------------------------------------
// Line assembler with overlong discard
// Assembles received bytes into lines, reads completed lines out byte by
// byte truncated to one less than the reader buffer size, and reports overlong lines.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                     Transfer when
//  rx_ch     in         rx_byte                     valid and ready
//  res_ch    out        kind, data_byte, last       valid and ready
//  cfg       in         cfg_data (out_capacity)     cfg_we
//
//  An ordinary byte or a line end that gives no result starts no read-out.
//  A line end starts a read-out of n bytes: the command passes through the
//  command queue, then each byte takes a store read, then a result.
//  Error and empty-line results skip the store read. Input is held off while
//  a read-out is queued or running, since it shares the line store.
//  Reset is asynchronous and clears control state; the store is not cleared.
//  A stalled result holds in place and delays the next store read.
// ----------------------------------------------------------------------------
module line_assembler_overlong_discard #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    lab_in_if.sink     rx_ch,
    lab_out_if.source  res_ch,
    input  logic       cfg_we,
    input  logic [6:0] cfg_data
);

    localparam int AW = $clog2(LINE_CAPACITY);

    logic             push;
    logic             pop;
    logic             back_busy;
    lab_pkg::cmd_t    push_cmd;
    lab_pkg::cmd_t    head;
    lab_pkg::q_stat_t q_stat;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;

    // Byte intake and classification.
    lab_front #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .back_busy (back_busy),
        .push      (push),
        .push_cmd  (push_cmd),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Command queue between the two halves.
    lab_cmd_q u_cmd_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    // Line store and result sequencer.
    lab_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .q_stat  (q_stat),
        .head    (head),
        .pop     (pop),
        .busy    (back_busy),
        .res     (res_ch)
    );

endmodule

[sv/lab_front.sv]
// ----------------------------------------------------------------------------
// Line assembler front end
// Accepts received bytes, stores line characters, tracks discard mode and
// issues one read-out command per completed line.
// ----------------------------------------------------------------------------
module lab_front #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lab_in_if.sink                          rx,
    input  logic                            cfg_we,
    input  logic [6:0]                      cfg_data,
    input  lab_pkg::q_stat_t                q_stat,
    input  logic                            back_busy,
    output logic                            push,
    output lab_pkg::cmd_t                   push_cmd,
    output logic                            wr_en,
    output logic [$clog2(LINE_CAPACITY)-1:0] wr_addr,
    output logic [7:0]                      wr_data
);

    localparam int AW = $clog2(LINE_CAPACITY);
    localparam int CW = AW + 7;
    localparam logic [AW-1:0] LEN_MAX = AW'(LINE_CAPACITY - 1);

    logic [6:0]    cap_reg;
    logic [AW-1:0] len_reg, len_next;
    logic          disc_reg, disc_next;

    logic                      accept;
    logic                      is_eol;
    logic [lab_pkg::CNT_W-1:0] cap_m1;
    logic [CW-1:0]             len_ext, cap_ext, n_ext;
    logic [lab_pkg::CNT_W-1:0] n_out;

    // New bytes wait while a line is still being read out of the store.
    assign rx.ready = !q_stat.full && q_stat.empty && !back_busy;
    assign accept   = rx.valid && rx.ready;
    assign is_eol   = (rx.rx_byte == lab_pkg::CHAR_CR) || (rx.rx_byte == lab_pkg::CHAR_LF);

    // Usable capacity minus one, with zero treated as one and a cap at the limit.
    always_comb
    begin
        priority if (cap_reg == 7'd0)
        begin
            cap_m1 = '0;
        end
        else if (cap_reg > lab_pkg::CAP_MAX)
        begin
            cap_m1 = lab_pkg::CNT_W'(lab_pkg::CAP_MAX - 7'd1);
        end
        else
        begin
            cap_m1 = lab_pkg::CNT_W'(cap_reg - 7'd1);
        end
    end

    // Number of bytes to read out: the shorter of line and capacity minus one.
    assign len_ext = {7'd0, len_reg};
    assign cap_ext = {{(CW - lab_pkg::CNT_W){1'b0}}, cap_m1};
    assign n_ext   = (len_ext < cap_ext) ? len_ext : cap_ext;
    assign n_out   = n_ext[lab_pkg::CNT_W-1:0];

    // Byte classification and next state.
    always_comb
    begin
        len_next       = len_reg;
        disc_next      = disc_reg;
        push           = 1'b0;
        push_cmd.kind  = lab_pkg::KIND_BYTE;
        push_cmd.count = n_out;
        wr_en          = 1'b0;
        wr_addr        = len_reg;
        wr_data        = rx.rx_byte;
        if (accept)
        begin
            if (is_eol)
            begin
                priority if (disc_reg)
                begin
                    disc_next     = 1'b0;
                    len_next      = '0;
                    push          = 1'b1;
                    push_cmd.kind = lab_pkg::KIND_TOO_LONG;
                end
                else if (len_reg != '0)
                begin
                    len_next      = '0;
                    push          = 1'b1;
                    push_cmd.kind = (n_out == '0) ? lab_pkg::KIND_EMPTY : lab_pkg::KIND_BYTE;
                end
                else
                begin
                    len_next = len_reg;
                end
            end
            else if (!disc_reg)
            begin
                if (len_reg < LEN_MAX)
                begin
                    wr_en    = 1'b1;
                    len_next = len_reg + AW'(1);
                end
                else
                begin
                    disc_next = 1'b1;
                    len_next  = '0;
                end
            end
        end
    end

    // Control registers and the capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= lab_pkg::CAP_RESET;
            len_reg  <= '0;
            disc_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            len_reg  <= len_next;
            disc_reg <= disc_next;
        end
    end

    // Discard mode always starts from an empty line.
    a_disc_empty: assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> (len_reg == '0))
        else $error("line length not cleared in discard mode");

    // The line never grows past the store.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_MAX)
        else $error("line length beyond store");

endmodule

[sv/lab_cmd_q.sv]
// ----------------------------------------------------------------------------
// Line assembler command queue
// Short first-in first-out queue of read-out commands from front to back.
// ----------------------------------------------------------------------------
module lab_cmd_q (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lab_pkg::cmd_t     push_cmd,
    input  logic              pop,
    output lab_pkg::cmd_t     head,
    output lab_pkg::q_stat_t  stat
);

    localparam int AW = lab_pkg::CMD_Q_AW;
    localparam int DW = AW + 1;
    localparam logic [DW-1:0] DEPTH = DW'(lab_pkg::CMD_Q_DEPTH);

    lab_pkg::cmd_t  q_reg [lab_pkg::CMD_Q_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [DW-1:0]  cnt_reg;

    assign head       = q_reg[rd_ptr_reg];
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == DEPTH);

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(lab_pkg::CMD_Q_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(lab_pkg::CMD_Q_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + DW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - DW'(1);
            end
        end
    end

    // A line read-out command always carries at least one byte.
    a_line_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (push_cmd.kind == lab_pkg::KIND_BYTE)) |-> (push_cmd.count != '0))
        else $error("line command with zero count");

endmodule

[sv/lab_back.sv]
// ----------------------------------------------------------------------------
// Line assembler back end
// Holds the line store and turns each command into result transfers,
// reading the stored line one byte at a time.
// ----------------------------------------------------------------------------
module lab_back #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [$clog2(LINE_CAPACITY)-1:0] wr_addr,
    input  logic [7:0]                       wr_data,
    input  lab_pkg::q_stat_t                 q_stat,
    input  lab_pkg::cmd_t                    head,
    output logic                             pop,
    output logic                             busy,
    lab_out_if.source                        res
);

    localparam int AW = $clog2(LINE_CAPACITY);
    localparam int CW = lab_pkg::CNT_W;

    logic [7:0] mem [LINE_CAPACITY];
    logic [7:0] rd_data_reg;

    lab_pkg::b_state_t state_reg, state_next;
    lab_pkg::kind_t    kind_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     idx_reg;

    logic             rd_en;
    logic             is_last;
    logic [AW+CW-1:0] idx_ext;
    logic [AW-1:0]    rd_addr;

    assign idx_ext = {{AW{1'b0}}, idx_reg};
    assign rd_addr = idx_ext[AW-1:0];
    assign is_last = (kind_reg != lab_pkg::KIND_BYTE) || (idx_reg == cnt_reg - CW'(1));

    // Line store with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lab_pkg::B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = (head.kind == lab_pkg::KIND_BYTE) ? lab_pkg::B_READ
                                                                   : lab_pkg::B_EMIT;
                end
            end
            lab_pkg::B_READ:
            begin
                state_next = lab_pkg::B_EMIT;
            end
            lab_pkg::B_EMIT:
            begin
                if (res.ready)
                begin
                    state_next = is_last ? lab_pkg::B_IDLE : lab_pkg::B_READ;
                end
            end
            default:
            begin
                state_next = lab_pkg::B_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        pop           = (state_reg == lab_pkg::B_IDLE) && !q_stat.empty;
        rd_en         = (state_reg == lab_pkg::B_READ);
        busy          = (state_reg != lab_pkg::B_IDLE);
        res.valid     = (state_reg == lab_pkg::B_EMIT);
        res.kind      = kind_reg;
        res.data_byte = (kind_reg == lab_pkg::KIND_BYTE) ? rd_data_reg : 8'd0;
        res.last      = is_last;
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lab_pkg::B_IDLE;
            kind_reg  <= lab_pkg::KIND_BYTE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                kind_reg <= head.kind;
                cnt_reg  <= head.count;
                idx_reg  <= '0;
            end
            else if (res.valid && res.ready && !is_last)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
        end
    end

    // The read index stays inside the line being read out.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != lab_pkg::B_IDLE) && (kind_reg == lab_pkg::KIND_BYTE))
            |-> (idx_reg < cnt_reg))
        else $error("read index past line end");

endmodule
